[src/qdc_pkg.sv]
// Shared types and constants for the QPLL divider calculator.
package qdc_pkg;

    localparam logic [19:0] REFCLK_MIN_KHZ = 20'd60000;
    localparam logic [19:0] REFCLK_MAX_KHZ = 20'd820000;
    localparam logic [23:0] RATE0_MIN_KBPS = 24'd9800000;
    localparam logic [23:0] RATE1_MIN_KBPS = 24'd8000000;
    localparam logic [23:0] RATE_MAX_KBPS  = 24'd12500000;
    localparam logic [7:0]  FB_LIMIT       = 8'd160;
    localparam logic [7:0]  FB_MIN         = 8'd2;
    localparam logic [7:0]  SECOND_BASE    = 8'h80;
    localparam logic [4:0]  M_ONE_CODE     = 5'd16;

    // quotient bits per divider chain, dividend and divisor widths
    localparam int QUO_W  = 8;
    localparam int DVD_W  = 25;
    localparam int DVS1_W = 21;
    localparam int DVS2_W = 5;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_REFCLK  = 3'd1,
        ST_RATE    = 3'd2,
        ST_FB_HIGH = 3'd3,
        ST_FB_LOW  = 3'd4
    } t_status;

    // side info that rides along the divider cells
    typedef struct packed {
        logic       sel;
        t_status    status;
        logic [4:0] fixed_div;
    } t_side;

    localparam int SIDE_W = $bits(t_side);

    typedef struct packed {
        t_status    status;
        logic [7:0] feedback_div;
        logic [2:0] ref_div;
        logic [4:0] out_div;
        logic [7:0] feedback_code;
        logic [4:0] ref_div_code;
        logic [7:0] reg_base;
    } t_result;

endpackage

[src/qpll_divider_calculator.sv]
// Top level of the QPLL divider calculator: range check, two divider chains, result register.
// Pipeline: 18 register stages (input
//   register, 8 cells of N = (2K+R)/(2R), 8 cells of N/D, output register).
// Throughput: one word per cycle; each division cell resolves one quotient bit.
// Stall: the whole pipeline holds while the output word waits for i_out_ready.
// Reset: synchronous active-low i_rst_n clears all valid bits; fixed_out_div resets to 1.
module qpll_divider_calculator (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_pll_select,
    input  logic [19:0] i_refclk_khz,
    input  logic [23:0] i_linerate_kbps,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_feedback_div,
    output logic [2:0]  o_ref_div,
    output logic [4:0]  o_out_div,
    output logic [7:0]  o_feedback_code,
    output logic [4:0]  o_ref_div_code,
    output logic [7:0]  o_reg_base
);

    localparam int QW    = qdc_pkg::QUO_W;
    localparam int SW    = qdc_pkg::SIDE_W;
    localparam int D1W   = qdc_pkg::DVS1_W;
    localparam int D2W   = qdc_pkg::DVS2_W;
    localparam int REM1W = D1W + QW;
    localparam int REM2W = D2W + QW;

    // Pipeline advance: the output register is empty or being drained.
    logic w_en;

    // Config register
    logic [4:0] r_fixed_out_div;

    // Input stage
    logic                     n_s0_lo_ok;
    qdc_pkg::t_side           n_s0_side;
    logic [qdc_pkg::DVD_W-1:0] n_s0_dvd;
    logic                     r_s0_valid;
    qdc_pkg::t_side           r_s0_side;
    logic [qdc_pkg::DVD_W-1:0] r_s0_dvd;
    logic [D1W-1:0]           r_s0_dvs;

    // First chain: N0 = (2K + R) / (2R)
    logic             s1_valid [0:QW];
    logic [REM1W-1:0] s1_rem   [0:QW];
    logic [D1W-1:0]   s1_dvs   [0:QW];
    logic [QW-1:0]    s1_quo   [0:QW];
    logic [SW-1:0]    s1_side  [0:QW];

    // Second chain: N1 = N0 / D
    logic             s2_valid [0:QW];
    logic [REM2W-1:0] s2_rem   [0:QW];
    logic [D2W-1:0]   s2_dvs   [0:QW];
    logic [QW-1:0]    s2_quo   [0:QW];
    logic [SW-1:0]    s2_side  [0:QW];

    qdc_pkg::t_side   w_mid_side;
    qdc_pkg::t_result w_res;

    // Output register
    logic             r_out_valid;
    qdc_pkg::t_result r_out;

    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixed_out_div <= 5'd1;
        end else if (i_cfg_we) begin
            r_fixed_out_div <= i_cfg_wdata;
        end
    end

    // Range checks; refclk failure takes precedence over line rate failure.
    always_comb begin
        n_s0_lo_ok = i_pll_select ? (i_linerate_kbps >= qdc_pkg::RATE1_MIN_KBPS)
                                  : (i_linerate_kbps >= qdc_pkg::RATE0_MIN_KBPS);
        n_s0_side.sel       = i_pll_select;
        n_s0_side.fixed_div = r_fixed_out_div;
        if (i_refclk_khz < qdc_pkg::REFCLK_MIN_KHZ || i_refclk_khz > qdc_pkg::REFCLK_MAX_KHZ) begin
            n_s0_side.status = qdc_pkg::ST_REFCLK;
        end else if (!n_s0_lo_ok || i_linerate_kbps > qdc_pkg::RATE_MAX_KBPS) begin
            n_s0_side.status = qdc_pkg::ST_RATE;
        end else begin
            n_s0_side.status = qdc_pkg::ST_OK;
        end
        // 2K + R; rounding half up comes from the added R
        n_s0_dvd = {i_linerate_kbps, 1'b0} + qdc_pkg::DVD_W'(i_refclk_khz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_side <= n_s0_side;
            r_s0_dvd  <= n_s0_dvd;
            r_s0_dvs  <= {i_refclk_khz, 1'b0};
        end
    end

    assign s1_valid[0] = r_s0_valid;
    assign s1_rem[0]   = REM1W'(r_s0_dvd);
    assign s1_dvs[0]   = r_s0_dvs;
    assign s1_quo[0]   = '0;
    assign s1_side[0]  = r_s0_side;

    // Quotient is below 256 for every in-range request; out-of-range
    // requests carry an error status and their quotient is discarded.
    for (genvar g = 0; g < QW; g++) begin : g_chain1
        qdc_div_cell #(
            .DVS_W  (D1W),
            .QUO_W  (QW),
            .BIT    (QW - 1 - g),
            .SIDE_W (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (s1_valid[g]),
            .i_rem   (s1_rem[g]),
            .i_dvs   (s1_dvs[g]),
            .i_quo   (s1_quo[g]),
            .i_side  (s1_side[g]),
            .o_valid (s1_valid[g+1]),
            .o_rem   (s1_rem[g+1]),
            .o_dvs   (s1_dvs[g+1]),
            .o_quo   (s1_quo[g+1]),
            .o_side  (s1_side[g+1])
        );
    end

    // Automatic mode divides by 1 here; a fixed D divides N0 directly.
    assign w_mid_side  = qdc_pkg::t_side'(s1_side[QW]);
    assign s2_valid[0] = s1_valid[QW];
    assign s2_rem[0]   = REM2W'(s1_quo[QW]);
    assign s2_dvs[0]   = (w_mid_side.fixed_div == 5'd0) ? D2W'(1) : w_mid_side.fixed_div;
    assign s2_quo[0]   = '0;
    assign s2_side[0]  = s1_side[QW];

    for (genvar g = 0; g < QW; g++) begin : g_chain2
        qdc_div_cell #(
            .DVS_W  (D2W),
            .QUO_W  (QW),
            .BIT    (QW - 1 - g),
            .SIDE_W (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (s2_valid[g]),
            .i_rem   (s2_rem[g]),
            .i_dvs   (s2_dvs[g]),
            .i_quo   (s2_quo[g]),
            .i_side  (s2_side[g]),
            .o_valid (s2_valid[g+1]),
            .o_rem   (s2_rem[g+1]),
            .o_dvs   (s2_dvs[g+1]),
            .o_quo   (s2_quo[g+1]),
            .o_side  (s2_side[g+1])
        );
    end

    qdc_post u_post (
        .i_quo  (s2_quo[QW]),
        .i_side (qdc_pkg::t_side'(s2_side[QW])),
        .o_res  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= s2_valid[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_feedback_div  = r_out.feedback_div;
    assign o_ref_div       = r_out.ref_div;
    assign o_out_div       = r_out.out_div;
    assign o_feedback_code = r_out.feedback_code;
    assign o_ref_div_code  = r_out.ref_div_code;
    assign o_reg_base      = r_out.reg_base;

endmodule

[src/qdc_div_cell.sv]
// One restoring-division cell: resolves one quotient bit and passes on.
module qdc_div_cell #(
    parameter int DVS_W  = 21,
    parameter int QUO_W  = 8,
    parameter int BIT    = 7,
    parameter int SIDE_W = 9
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [DVS_W+QUO_W-1:0] i_rem,
    input  logic [DVS_W-1:0]       i_dvs,
    input  logic [QUO_W-1:0]       i_quo,
    input  logic [SIDE_W-1:0]      i_side,
    output logic                   o_valid,
    output logic [DVS_W+QUO_W-1:0] o_rem,
    output logic [DVS_W-1:0]       o_dvs,
    output logic [QUO_W-1:0]       o_quo,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int REM_W = DVS_W + QUO_W;

    logic [REM_W-1:0]  w_shifted;
    logic              w_ge;
    logic [REM_W-1:0]  n_rem;
    logic [QUO_W-1:0]  n_quo;

    logic              r_valid;
    logic [REM_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [QUO_W-1:0]  r_quo;
    logic [SIDE_W-1:0] r_side;

    always_comb begin
        w_shifted  = REM_W'(i_dvs) << BIT;
        w_ge       = (i_rem >= w_shifted);
        n_rem      = w_ge ? (i_rem - w_shifted) : i_rem;
        n_quo      = i_quo;
        n_quo[BIT] = w_ge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_dvs  <= i_dvs;
            r_quo  <= n_quo;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_dvs   = r_dvs;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

endmodule

[src/qdc_post.sv]
// Final selection of M and D, status and register field codes.
module qdc_post (
    input  logic [qdc_pkg::QUO_W-1:0] i_quo,
    input  qdc_pkg::t_side            i_side,
    output qdc_pkg::t_result          o_res
);

    logic       w_halve;
    logic [7:0] w_n;
    logic [2:0] w_m;
    logic [4:0] w_d;
    qdc_pkg::t_status w_status;

    // An 8-bit N over 160 always drops below 160 at M = 2, and the halved
    // value never exceeds 160, so the automatic D search settles at 1.
    always_comb begin
        w_halve = (i_quo > qdc_pkg::FB_LIMIT);
        w_n     = w_halve ? (i_quo >> 1) : i_quo;
        w_m     = w_halve ? 3'd2 : 3'd1;
        w_d     = (i_side.fixed_div == 5'd0) ? 5'd1 : i_side.fixed_div;

        if (i_side.status != qdc_pkg::ST_OK) begin
            w_status = i_side.status;
        end else if (w_n > qdc_pkg::FB_LIMIT) begin
            w_status = qdc_pkg::ST_FB_HIGH;
        end else if (w_n < qdc_pkg::FB_MIN) begin
            w_status = qdc_pkg::ST_FB_LOW;
        end else begin
            w_status = qdc_pkg::ST_OK;
        end

        o_res        = '0;
        o_res.status = w_status;
        if (w_status == qdc_pkg::ST_OK) begin
            o_res.feedback_div  = w_n;
            o_res.ref_div       = w_m;
            o_res.out_div       = w_d;
            o_res.feedback_code = w_n - qdc_pkg::FB_MIN;
            o_res.ref_div_code  = (w_m == 3'd1) ? qdc_pkg::M_ONE_CODE : 5'(w_m - 3'd2);
            o_res.reg_base      = i_side.sel ? qdc_pkg::SECOND_BASE : 8'd0;
        end
    end

endmodule
